/* sv/sliding_window_minmax_normalizer_core_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the sliding window min/max normalizer
// Clocked property checks that can be removed by defining NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MINMAX_NORMALIZER_CORE_DEFINES_SVH
`define SLIDING_WINDOW_MINMAX_NORMALIZER_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SWMM_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define SWMM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SWMM_ASSERT(lbl, clk, rstn, prop, msg)
`define SWMM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* sv/swmm_pkg.sv */
// ----------------------------------------------------------------------------
// swmm_pkg
// Shared constants, codes and types of the sliding window normalizer.
// ----------------------------------------------------------------------------
`default_nettype none
package swmm_pkg;

    localparam int WINDOW_DEPTH = 1024;
    localparam int SAMPLE_BITS  = 32;
    localparam int ADDR_BITS    = $clog2(WINDOW_DEPTH);
    localparam int LEN_BITS     = $clog2(WINDOW_DEPTH + 1);
    localparam int FRAC_BITS    = 14;
    localparam int QUO_BITS     = FRAC_BITS + 1;
    localparam int NORM_BITS    = 16;
    localparam int REM_BITS     = SAMPLE_BITS + 1;
    localparam int IDX_BITS     = 2;
    localparam int CFG_BITS     = LEN_BITS;

    localparam logic [LEN_BITS-1:0]  LEN_MIN   = LEN_BITS'(2);
    localparam logic [LEN_BITS-1:0]  LEN_MAX   = LEN_BITS'(WINDOW_DEPTH);
    localparam logic [LEN_BITS-1:0]  LEN_RESET = LEN_BITS'(10);
    localparam logic [NORM_BITS-1:0] NORM_ONE  = NORM_BITS'(1 << FRAC_BITS);
    localparam logic [NORM_BITS-1:0] NORM_ZERO = '0;

    typedef enum logic [IDX_BITS-1:0] {
        REG_WINDOW_LENGTH = 2'd0,
        REG_LOG_MODE      = 2'd1,
        REG_NORMALIZE_ON  = 2'd2,
        REG_UNUSED        = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WRITE,
        S_SCAN,
        S_UPDATE,
        S_PREP,
        S_DIV,
        S_DONE
    } state_t;

    typedef struct packed {
        logic                   valid;
        logic                   bypass;
        logic [NORM_BITS-1:0]   bypass_val;
        logic                   neg;
        logic [REM_BITS-1:0]    rem;
        logic [SAMPLE_BITS-1:0] den;
        logic [QUO_BITS-1:0]    quo;
    } div_tok_t;

endpackage
`default_nettype wire

/* sv/swmm_div_cell.sv */
// ----------------------------------------------------------------------------
// swmm_div_cell
// One restoring division step: resolves one quotient bit, passes on.
// ----------------------------------------------------------------------------
`default_nettype none
module swmm_div_cell (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire swmm_pkg::div_tok_t tok_in,
    output swmm_pkg::div_tok_t      tok_out
);

    logic                                 valid_reg;
    swmm_pkg::div_tok_t                   data_reg;
    swmm_pkg::div_tok_t                   data_next;
    logic                                 ge;
    logic [swmm_pkg::REM_BITS-1:0]        diff;
    logic [swmm_pkg::REM_BITS-1:0]        kept;

    always_comb
    begin
        ge   = tok_in.rem >= {1'b0, tok_in.den};
        diff = tok_in.rem - {1'b0, tok_in.den};
        kept = ge ? diff : tok_in.rem;
        data_next       = tok_in;
        data_next.rem   = {kept[swmm_pkg::REM_BITS-2:0], 1'b0};
        data_next.quo   = {tok_in.quo[swmm_pkg::QUO_BITS-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= tok_in.valid;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_comb
    begin
        tok_out       = data_reg;
        tok_out.valid = valid_reg;
    end

endmodule
`default_nettype wire

/* sv/swmm_div_chain.sv */
// ----------------------------------------------------------------------------
// swmm_div_chain
// Row of division cells, one quotient bit per cell, MSB first.
// ----------------------------------------------------------------------------
`default_nettype none
module swmm_div_chain (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire swmm_pkg::div_tok_t tok_in,
    output swmm_pkg::div_tok_t      tok_out
);

    swmm_pkg::div_tok_t link [swmm_pkg::QUO_BITS+1];

    assign link[0] = tok_in;

    for (genvar k = 0; k < swmm_pkg::QUO_BITS; k++)
    begin : g_cell
        swmm_div_cell u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .tok_in (link[k]),
            .tok_out(link[k+1])
        );
    end

    assign tok_out = link[swmm_pkg::QUO_BITS];

endmodule
`default_nettype wire

/* sv/sliding_window_minmax_normalizer_core.sv */
// ----------------------------------------------------------------------------
// sliding_window_minmax_normalizer_core
// Sliding window min/max tracker with normalized sample output.
// ----------------------------------------------------------------------------
// One sample in, one result (min, max, normalized) out per transaction. Each
// accepted sample passes through store write, extreme update, operand setup,
// the row of division cells (one quotient bit per cell), divider handoff and
// output load; no new sample is accepted until its result is loaded into the
// output register. When the sample leaving the window equals the current min
// or max, the window store (one read port) is rescanned before the extreme
// update. The next sample is taken while a result still waits on the output.
`default_nettype none
`include "sliding_window_minmax_normalizer_core_defines.svh"
module sliding_window_minmax_normalizer_core (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [swmm_pkg::IDX_BITS-1:0]       cfg_index,
    input  wire logic [swmm_pkg::CFG_BITS-1:0]       cfg_data,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic signed [swmm_pkg::SAMPLE_BITS-1:0] sample,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic signed [swmm_pkg::SAMPLE_BITS-1:0]  window_min,
    output logic signed [swmm_pkg::SAMPLE_BITS-1:0]  window_max,
    output logic signed [swmm_pkg::NORM_BITS-1:0]    normalized
);

    localparam int SB = swmm_pkg::SAMPLE_BITS;
    localparam int AB = swmm_pkg::ADDR_BITS;
    localparam int LB = swmm_pkg::LEN_BITS;
    localparam int NB = swmm_pkg::NORM_BITS;

    logic [SB-1:0] mem [swmm_pkg::WINDOW_DEPTH];

    swmm_pkg::state_t    state_reg, state_next;
    logic [LB-1:0]       len_reg;
    logic                log_reg;
    logic                norm_on_reg;
    logic [LB-1:0]       fill_reg;
    logic [AB-1:0]       wp_reg;
    logic signed [SB-1:0] min_reg, max_reg;
    logic                valid_reg;
    logic signed [SB-1:0] v_reg;
    logic [SB-1:0]       rd_data_reg;
    logic [AB-1:0]       rd_addr;
    logic                lo_hit_reg, hi_hit_reg;
    logic [LB-1:0]       scan_cnt_reg;
    logic                pend_reg;
    logic                first_reg;
    logic signed [SB-1:0] lo_reg, hi_reg;
    logic [NB-1:0]       res_norm_reg;
    logic                out_valid_reg;
    logic signed [SB-1:0] out_min_reg, out_max_reg;
    logic [NB-1:0]       out_norm_reg;

    swmm_pkg::div_tok_t  tok_in, tok_out;

    logic                in_fire, out_fire, load_out;
    logic [LB-1:0]       cfg_len;
    logic [LB-1:0]       wp_inc;
    logic signed [SB-1:0] old_val;
    logic                dropped, rescan;
    logic                scan_done;
    logic [SB:0]         lin_num, lin_den;
    logic [SB-1:0]       mag_min, mag_max, mag_v, mag_den;

    assign in_fire  = in_valid && !in_stall;
    assign out_fire = out_valid_reg && !out_stall;
    assign load_out = (state_reg == swmm_pkg::S_DONE) && (!out_valid_reg || !out_stall);
    assign in_stall = state_reg != swmm_pkg::S_IDLE;

    always_comb
    begin
        if (cfg_data < swmm_pkg::LEN_MIN)
            cfg_len = swmm_pkg::LEN_MIN;
        else if (cfg_data > swmm_pkg::LEN_MAX)
            cfg_len = swmm_pkg::LEN_MAX;
        else
            cfg_len = cfg_data;
    end

    assign wp_inc    = {1'b0, wp_reg} + LB'(1);
    assign old_val   = $signed(rd_data_reg);
    assign dropped   = fill_reg >= len_reg;
    assign rescan    = dropped && valid_reg && (old_val <= min_reg || old_val >= max_reg);
    assign scan_done = (scan_cnt_reg == fill_reg) && !pend_reg;
    assign rd_addr   = (state_reg == swmm_pkg::S_SCAN) ? scan_cnt_reg[AB-1:0] : wp_reg;

    // window store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (state_reg == swmm_pkg::S_WRITE)
            mem[wp_reg] <= v_reg;
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            swmm_pkg::S_IDLE:
                if (in_fire)
                    state_next = swmm_pkg::S_WRITE;
            swmm_pkg::S_WRITE:
                state_next = rescan ? swmm_pkg::S_SCAN : swmm_pkg::S_UPDATE;
            swmm_pkg::S_SCAN:
                if (scan_done)
                    state_next = swmm_pkg::S_UPDATE;
            swmm_pkg::S_UPDATE:
                state_next = swmm_pkg::S_PREP;
            swmm_pkg::S_PREP:
                state_next = swmm_pkg::S_DIV;
            swmm_pkg::S_DIV:
                if (tok_out.valid)
                    state_next = swmm_pkg::S_DONE;
            swmm_pkg::S_DONE:
                if (load_out)
                    state_next = swmm_pkg::S_IDLE;
            default:
                state_next = swmm_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= swmm_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg     <= swmm_pkg::LEN_RESET;
            log_reg     <= 1'b0;
            norm_on_reg <= 1'b0;
            fill_reg    <= '0;
            wp_reg      <= '0;
            min_reg     <= '0;
            max_reg     <= '0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (swmm_pkg::reg_idx_t'(cfg_index))
                    swmm_pkg::REG_WINDOW_LENGTH:
                    begin
                        len_reg   <= cfg_len;
                        fill_reg  <= '0;
                        wp_reg    <= '0;
                        min_reg   <= '0;
                        max_reg   <= '0;
                        valid_reg <= 1'b0;
                    end
                    swmm_pkg::REG_LOG_MODE:     log_reg     <= cfg_data[0];
                    swmm_pkg::REG_NORMALIZE_ON: norm_on_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            if (state_reg == swmm_pkg::S_WRITE)
            begin
                wp_reg <= (wp_inc >= len_reg) ? '0 : wp_inc[AB-1:0];
                if (!dropped)
                    fill_reg <= fill_reg + LB'(1);
            end
            if (state_reg == swmm_pkg::S_SCAN && scan_done)
            begin
                if (lo_hit_reg)
                    min_reg <= lo_reg;
                if (hi_hit_reg)
                    max_reg <= hi_reg;
            end
            if (state_reg == swmm_pkg::S_UPDATE)
            begin
                if (!valid_reg || v_reg < min_reg)
                    min_reg <= v_reg;
                if (!valid_reg || v_reg > max_reg)
                    max_reg <= v_reg;
                valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            v_reg <= sample;
        if (state_reg == swmm_pkg::S_WRITE)
        begin
            lo_hit_reg   <= old_val <= min_reg;
            hi_hit_reg   <= old_val >= max_reg;
            scan_cnt_reg <= '0;
            pend_reg     <= 1'b0;
            first_reg    <= 1'b1;
        end
        if (state_reg == swmm_pkg::S_SCAN)
        begin
            pend_reg <= scan_cnt_reg != fill_reg;
            if (scan_cnt_reg != fill_reg)
                scan_cnt_reg <= scan_cnt_reg + LB'(1);
            if (pend_reg)
            begin
                first_reg <= 1'b0;
                if (first_reg || old_val < lo_reg)
                    lo_reg <= old_val;
                if (first_reg || old_val > hi_reg)
                    hi_reg <= old_val;
            end
        end
        if (state_reg == swmm_pkg::S_DIV && tok_out.valid)
        begin
            if (tok_out.bypass)
                res_norm_reg <= tok_out.bypass_val;
            else if (tok_out.neg)
                res_norm_reg <= NB'(0) - {{(NB - swmm_pkg::QUO_BITS){1'b0}}, tok_out.quo};
            else
                res_norm_reg <= {{(NB - swmm_pkg::QUO_BITS){1'b0}}, tok_out.quo};
        end
        if (load_out)
        begin
            out_min_reg  <= min_reg;
            out_max_reg  <= max_reg;
            out_norm_reg <= res_norm_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_out)
            out_valid_reg <= 1'b1;
        else if (out_fire)
            out_valid_reg <= 1'b0;
    end

    // divider operands
    always_comb
    begin
        lin_num = {v_reg[SB-1], v_reg} - {min_reg[SB-1], min_reg};
        lin_den = {max_reg[SB-1], max_reg} - {min_reg[SB-1], min_reg};
        mag_min = min_reg[SB-1] ? SB'(0) - min_reg : min_reg;
        mag_max = max_reg[SB-1] ? SB'(0) - max_reg : max_reg;
        mag_v   = v_reg[SB-1] ? SB'(0) - v_reg : v_reg;
        mag_den = (mag_min > mag_max) ? mag_min : mag_max;

        tok_in            = '0;
        tok_in.valid      = state_reg == swmm_pkg::S_PREP;
        tok_in.bypass_val = swmm_pkg::NORM_ZERO;
        if (!norm_on_reg)
            tok_in.bypass = 1'b1;
        else if (log_reg)
        begin
            tok_in.bypass = mag_den == '0;
            tok_in.neg    = v_reg[SB-1];
            tok_in.rem    = {1'b0, mag_v};
            tok_in.den    = mag_den;
        end
        else if (max_reg == min_reg)
        begin
            tok_in.bypass     = 1'b1;
            tok_in.bypass_val = (max_reg == '0) ? swmm_pkg::NORM_ZERO : swmm_pkg::NORM_ONE;
        end
        else
        begin
            tok_in.rem = {1'b0, lin_num[SB-1:0]};
            tok_in.den = lin_den[SB-1:0];
        end
    end

    swmm_div_chain u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .tok_in (tok_in),
        .tok_out(tok_out)
    );

    assign out_valid  = out_valid_reg;
    assign window_min = out_min_reg;
    assign window_max = out_max_reg;
    assign normalized = $signed(out_norm_reg);

    `SWMM_ASSERT(a_accept_to_write, clk, rst_n, in_fire |=> state_reg == swmm_pkg::S_WRITE, "accepted transaction did not reach store write")
    `SWMM_ASSERT(a_min_le_max, clk, rst_n, !valid_reg || min_reg <= max_reg, "window min above window max")
    `SWMM_ASSERT(a_fill_bound, clk, rst_n, fill_reg <= len_reg, "fill count exceeds window length")
    `SWMM_ASSERT(a_div_only_in_div, clk, rst_n, tok_out.valid |-> state_reg == swmm_pkg::S_DIV, "divider result outside divide phase")

endmodule
`default_nettype wire

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// Sliding window min/max normalizer testbench
// Drives samples through the valid/stall channels with random gaps, predicts
// window min, max and normalized value per transaction and compares them in
// order. Runs several window lengths and modes, including the extremes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb;

    typedef struct packed {
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        logic signed [15:0] norm;
    } minmax_t;

    typedef struct {
        logic signed [31:0] s;
        bit                 has_exp;
        minmax_t            exp;
    } dir_row_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_we = 1'b0;
    logic [swmm_pkg::IDX_BITS-1:0]  cfg_index = swmm_pkg::REG_WINDOW_LENGTH;
    logic [swmm_pkg::CFG_BITS-1:0]  cfg_data = '0;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    logic signed [31:0]             sample = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic signed [31:0]             window_min;
    logic signed [31:0]             window_max;
    logic signed [15:0]             normalized;

    sliding_window_minmax_normalizer_core i_dut (.*);

    always #5 clk = ~clk;

    // predictor state
    logic signed [31:0] win_mem [swmm_pkg::WINDOW_DEPTH];
    int unsigned        n_filled, wr_ptr, win_len;
    logic signed [31:0] cur_lo, cur_hi;
    bit                 have_ext, log_sel, norm_en;

    minmax_t  pending_q[$];
    minmax_t  typed_q[$];
    bit       typed_has_q[$];
    int       n_err = 0, n_seen = 0, n_sent = 0, n_rescan = 0;
    longint   cyc = 0;
    bit       hold_long = 1'b0;

    function automatic logic signed [15:0] scale_sample(logic signed [31:0] v);
        logic [63:0] a, b, d, q, num;
        if (!norm_en) return '0;
        if (log_sel) begin
            a = cur_lo < 0 ? 64'(-64'(cur_lo)) : 64'(cur_lo);
            b = cur_hi < 0 ? 64'(-64'(cur_hi)) : 64'(cur_hi);
            d = a > b ? a : b;
            if (d == 0) return '0;
            num = v < 0 ? 64'(-64'(v)) : 64'(v);
            q = (num * 64'd16384) / d;
            return v < 0 ? 16'(-q) : 16'(q);
        end
        if (cur_hi == cur_lo) return cur_hi == 0 ? 16'sd0 : 16'sd16384;
        num = 64'(64'(v) - 64'(cur_lo));
        d = 64'(64'(cur_hi) - 64'(cur_lo));
        return 16'((num * 64'd16384) / d);
    endfunction

    function automatic minmax_t track_sample(logic signed [31:0] v);
        minmax_t r;
        logic signed [31:0] old, lo, hi;
        bit drop;
        drop = 0;
        old = '0;
        if (wr_ptr >= win_len) wr_ptr = 0;
        if (n_filled >= win_len)
        begin
            drop = 1;
            old = win_mem[wr_ptr];
        end
        win_mem[wr_ptr] = v;
        wr_ptr = (wr_ptr + 1 >= win_len) ? 0 : wr_ptr + 1;
        if (n_filled < win_len) n_filled++;
        if (drop && have_ext && (old <= cur_lo || old >= cur_hi))
        begin
            n_rescan++;
            lo = win_mem[0];
            hi = win_mem[0];
            for (int i = 1; i < n_filled; i++)
            begin
                if (win_mem[i] < lo) lo = win_mem[i];
                if (win_mem[i] > hi) hi = win_mem[i];
            end
            if (old <= cur_lo) cur_lo = lo;
            if (old >= cur_hi) cur_hi = hi;
        end
        if (!have_ext || v < cur_lo) cur_lo = v;
        if (!have_ext || v > cur_hi) cur_hi = v;
        have_ext = 1;
        r.lo = cur_lo;
        r.hi = cur_hi;
        r.norm = scale_sample(v);
        return r;
    endfunction

    task automatic write_reg(swmm_pkg::reg_idx_t idx, int unsigned val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= swmm_pkg::CFG_BITS'(val);
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            swmm_pkg::REG_WINDOW_LENGTH:
            begin
                win_len = val < 2 ? 2 :
                          (val > swmm_pkg::WINDOW_DEPTH ? swmm_pkg::WINDOW_DEPTH : val);
                n_filled = 0;
                wr_ptr = 0;
                cur_lo = 0;
                cur_hi = 0;
                have_ext = 0;
            end
            swmm_pkg::REG_LOG_MODE: log_sel = val[0];
            swmm_pkg::REG_NORMALIZE_ON: norm_en = val[0];
            default: ;
        endcase
    endtask

    task automatic send_sample(logic signed [31:0] v, bit has_exp, minmax_t exp);
        minmax_t p;
        int      w;
        w = $urandom_range(0, 1) ? 0 : $urandom_range(0, 12);
        if (w != 0)
        begin
            in_valid <= 1'b0;
            repeat (w) @(posedge clk);
        end
        p = track_sample(v);
        pending_q.insert(pending_q.size(), p);
        typed_q.insert(typed_q.size(), exp);
        typed_has_q.insert(typed_has_q.size(), has_exp);
        in_valid <= 1'b1;
        sample <= v;
        do @(posedge clk); while (in_stall);
        n_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk);
        repeat (1100) @(posedge clk);
    endtask

    function automatic logic signed [31:0] rand_sample(int mode);
        case (mode)
            0: return $urandom;
            1: return $signed($urandom_range(0, 40)) - 20;
            2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            default: return $signed($urandom_range(0, 2000)) - 1000;
        endcase
    endfunction

    // receiver
    initial
    begin
        int w;
        @(posedge rst_n);
        forever
        begin
            if (hold_long)
            begin
                out_stall <= 1'b1;
                repeat (3000) @(posedge clk);
                hold_long = 0;
            end
            else
            begin
                w = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 12);
                if (w != 0)
                begin
                    out_stall <= 1'b1;
                    repeat (w) @(posedge clk);
                end
            end
            out_stall <= 1'b0;
            @(posedge clk);
        end
    end

    // checker
    always @(posedge clk)
    begin
        minmax_t e, t;
        bit th;
        if (rst_n && out_valid && !out_stall)
        begin
            n_seen++;
            if (pending_q.size() == 0)
            begin
                n_err++;
                $display("%0t: unexpected result min=%0d max=%0d norm=%0d", $time,
                         window_min, window_max, normalized);
            end
            else
            begin
                e = pending_q.pop_front();
                t = typed_q.pop_front();
                th = typed_has_q.pop_front();
                if (th && t != e)
                begin
                    n_err++;
                    $display("%0t: table row disagrees: exp %p pred %p", $time, t, e);
                end
                if (window_min !== e.lo)
                begin
                    n_err++;
                    $display("%0t: window_min exp %0d got %0d", $time, e.lo, window_min);
                end
                if (window_max !== e.hi)
                begin
                    n_err++;
                    $display("%0t: window_max exp %0d got %0d", $time, e.hi, window_max);
                end
                if (normalized !== e.norm)
                begin
                    n_err++;
                    $display("%0t: normalized exp %0d got %0d", $time, e.norm, normalized);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cyc++;
        if (cyc > 5_000_000)
        begin
            $display("timeout after %0d cycles, %0d results pending", cyc, pending_q.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        dir_row_t rows[$];
        minmax_t  z;
        int       lens[6];
        int       n, mode;
        z = '0;
        win_len = swmm_pkg::LEN_RESET;
        n_filled = 0;
        wr_ptr = 0;
        cur_lo = 0;
        cur_hi = 0;
        have_ext = 0;
        log_sel = 0;
        norm_en = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // reset defaults: window 10, normalization off
        rows.insert(rows.size(), '{32'sh7fffffff, 1, '{32'sh7fffffff, 32'sh7fffffff, 16'sd0}});
        rows.insert(rows.size(), '{32'sh80000000, 1, '{32'sh80000000, 32'sh7fffffff, 16'sd0}});
        rows.insert(rows.size(), '{0, 1, '{32'sh80000000, 32'sh7fffffff, 16'sd0}});
        foreach (rows[i]) send_sample(rows[i].s, rows[i].has_exp, rows[i].exp);
        drain();

        // linear, window 2: flat windows and drops of extremes
        write_reg(swmm_pkg::REG_NORMALIZE_ON, 1);
        write_reg(swmm_pkg::REG_LOG_MODE, 0);
        write_reg(swmm_pkg::REG_WINDOW_LENGTH, 0);
        rows = {};
        rows.insert(rows.size(), '{0, 1, '{0, 0, 16'sd0}});
        rows.insert(rows.size(), '{0, 1, '{0, 0, 16'sd0}});
        rows.insert(rows.size(), '{5, 1, '{0, 5, 16'sd16384}});
        rows.insert(rows.size(), '{5, 1, '{5, 5, 16'sd16384}});
        rows.insert(rows.size(), '{32'sh80000000, 1, '{32'sh80000000, 5, 16'sd0}});
        rows.insert(rows.size(),
                    '{32'sh7fffffff, 1, '{32'sh80000000, 32'sh7fffffff, 16'sd16384}});
        rows.insert(rows.size(), '{-3, 0, z});
        rows.insert(rows.size(), '{-3, 0, z});
        foreach (rows[i]) send_sample(rows[i].s, rows[i].has_exp, rows[i].exp);
        drain();

        // log mode, zero magnitude and extremes
        write_reg(swmm_pkg::REG_LOG_MODE, 1);
        write_reg(swmm_pkg::REG_WINDOW_LENGTH, 3);
        rows = {};
        rows.insert(rows.size(), '{0, 1, '{0, 0, 16'sd0}});
        rows.insert(rows.size(), '{32'sh80000000, 1, '{32'sh80000000, 0, -16'sd16384}});
        rows.insert(rows.size(), '{32'sh7fffffff, 0, z});
        rows.insert(rows.size(), '{-7, 0, z});
        rows.insert(rows.size(), '{100, 0, z});
        rows.insert(rows.size(), '{0, 0, z});
        foreach (rows[i]) send_sample(rows[i].s, rows[i].has_exp, rows[i].exp);
        drain();
        write_reg(swmm_pkg::REG_UNUSED, 5);
        write_reg(swmm_pkg::REG_WINDOW_LENGTH, 2047);
        send_sample(-1, 1, '{-1, -1, -16'sd16384});
        drain();

        // random phases across lengths and modes
        lens = '{1024, 2, 7, 33, 5, 130};
        foreach (lens[k])
        begin
            write_reg(swmm_pkg::REG_WINDOW_LENGTH, lens[k]);
            write_reg(swmm_pkg::REG_LOG_MODE, $urandom_range(0, 1));
            write_reg(swmm_pkg::REG_NORMALIZE_ON, k == 4 ? 0 : 1);
            n = lens[k] == 1024 ? 40 : 96;
            if (k == 2) hold_long = 1;
            mode = $urandom_range(0, 3);
            for (int j = 0; j < n; j++)
                send_sample(rand_sample($urandom_range(0, 3) == 0 ? $urandom_range(0, 3) : mode),
                            0, z);
            drain();
        end

        $display("sent %0d samples, checked %0d results, %0d window rescans predicted",
                 n_sent, n_seen, n_rescan);
        $display("window lengths 2..1024 covered in linear, log and disabled modes");
        if (n_err == 0 && pending_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

/* sliding_window_minmax_normalizer_core.f */
+incdir+sv
sv/swmm_pkg.sv
sv/swmm_div_cell.sv
sv/swmm_div_chain.sv
sv/sliding_window_minmax_normalizer_core.sv
dv/tb.sv
